@@ hw/rtl/trsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsc_pkg
// Types, command codes and rotor wiring tables for the three-rotor cipher.
// Symbols are coded 0 for '#' and 1..26 for 'A'..'Z'.
// ----------------------------------------------------------------------------
package trsc_pkg;

   localparam int ALPHABET_SIZE = 27;
   localparam int SYM_W         = 5;

   typedef logic [SYM_W-1:0] sym_type;
   typedef logic [1:0]       cmd_type;
   typedef logic [7:0]       byte_type;

   localparam cmd_type CMD_ENCODE = 2'd0;
   localparam cmd_type CMD_DECODE = 2'd1;
   localparam cmd_type CMD_REWIND = 2'd2;
   localparam cmd_type CMD_UNUSED = 2'd3;

   localparam byte_type CHAR_HASH  = 8'h23;
   localparam byte_type CHAR_SPACE = 8'h20;
   localparam byte_type CHAR_UC_A  = 8'h41;
   localparam byte_type CHAR_UC_Z  = 8'h5A;
   localparam byte_type CHAR_LC_A  = 8'h61;
   localparam byte_type CHAR_LC_Z  = 8'h7A;
   localparam byte_type CASE_DIFF  = 8'h20;
   localparam byte_type UC_BASE    = 8'h40;

   // Rotor wiring, position to symbol.
   localparam sym_type TAB_OUT [ALPHABET_SIZE] = '{
      5'd0,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14, 5'd16,
      5'd18, 5'd20, 5'd22, 5'd24, 5'd26, 5'd1,  5'd3,  5'd5,  5'd7,
      5'd9,  5'd11, 5'd13, 5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25};
   localparam sym_type TAB_MID [ALPHABET_SIZE] = '{
      5'd0,  5'd5,  5'd10, 5'd15, 5'd20, 5'd25, 5'd3,  5'd8,  5'd13,
      5'd18, 5'd23, 5'd1,  5'd6,  5'd11, 5'd16, 5'd21, 5'd26, 5'd4,
      5'd9,  5'd14, 5'd19, 5'd24, 5'd2,  5'd7,  5'd12, 5'd17, 5'd22};
   localparam sym_type TAB_INN [ALPHABET_SIZE] = '{
      5'd0,  5'd7,  5'd14, 5'd21, 5'd1,  5'd8,  5'd15, 5'd22, 5'd2,
      5'd9,  5'd16, 5'd23, 5'd3,  5'd10, 5'd17, 5'd24, 5'd4,  5'd11,
      5'd18, 5'd25, 5'd5,  5'd12, 5'd19, 5'd26, 5'd6,  5'd13, 5'd20};

   // Inverse wiring, symbol to position.
   localparam sym_type INV_OUT [ALPHABET_SIZE] = '{
      5'd0,  5'd14, 5'd1,  5'd15, 5'd2,  5'd16, 5'd3,  5'd17, 5'd4,
      5'd18, 5'd5,  5'd19, 5'd6,  5'd20, 5'd7,  5'd21, 5'd8,  5'd22,
      5'd9,  5'd23, 5'd10, 5'd24, 5'd11, 5'd25, 5'd12, 5'd26, 5'd13};
   localparam sym_type INV_MID [ALPHABET_SIZE] = '{
      5'd0,  5'd11, 5'd22, 5'd6,  5'd17, 5'd1,  5'd12, 5'd23, 5'd7,
      5'd18, 5'd2,  5'd13, 5'd24, 5'd8,  5'd19, 5'd3,  5'd14, 5'd25,
      5'd9,  5'd20, 5'd4,  5'd15, 5'd26, 5'd10, 5'd21, 5'd5,  5'd16};
   localparam sym_type INV_INN [ALPHABET_SIZE] = '{
      5'd0,  5'd4,  5'd8,  5'd12, 5'd16, 5'd20, 5'd24, 5'd1,  5'd5,
      5'd9,  5'd13, 5'd17, 5'd21, 5'd25, 5'd2,  5'd6,  5'd10, 5'd14,
      5'd18, 5'd22, 5'd26, 5'd3,  5'd7,  5'd11, 5'd15, 5'd19, 5'd23};

   localparam logic [SYM_W:0] MOD_WIDE = (SYM_W+1)'(ALPHABET_SIZE);

   function automatic sym_type add_mod(input sym_type a, input sym_type b);
      logic [SYM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= MOD_WIDE) begin
         s = s - MOD_WIDE;
      end
      return s[SYM_W-1:0];
   endfunction

   function automatic sym_type sub_mod(input sym_type a, input sym_type b);
      logic [SYM_W:0] s;
      s = {1'b0, a} + MOD_WIDE - {1'b0, b};
      if (s >= MOD_WIDE) begin
         s = s - MOD_WIDE;
      end
      return s[SYM_W-1:0];
   endfunction

   function automatic byte_type sym_to_char(input sym_type s);
      return (s == '0) ? CHAR_HASH : (UC_BASE + {3'b000, s});
   endfunction

endpackage

@@ hw/rtl/three_rotor_substitution_cipher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_rotor_substitution_cipher
// Byte-wide three-rotor cipher: one character in, at most one character out.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/stall     req_cmd, req_char_in
//   rsp      out        rsp_valid/stall     rsp_char_out, rsp_substituted
//
// One character per cycle sustained while rsp is not stalled. A character
// enters the input register, then takes the rotor path to the result register.
// Reset clears both rotor offsets to the home position and empties both
// registers. A stall on rsp holds the result and backs up into req_stall
// only when the input register is also occupied.
// ----------------------------------------------------------------------------
module three_rotor_substitution_cipher
   import trsc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  cmd_type  req_cmd,
   input  byte_type req_char_in,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output byte_type rsp_char_out,
   output logic     rsp_substituted
);

   // Input register.
   logic     s1_valid_ff, s1_valid_in;
   cmd_type  s1_cmd_ff;
   byte_type s1_char_ff;
   logic     s1_alpha_ff;
   sym_type  s1_inn_pos_ff;
   sym_type  s1_out_pos_ff;

   // Rotor state.
   sym_type  inner_offset_ff, inner_offset_in;
   sym_type  middle_offset_ff, middle_offset_in;

   // Result register.
   logic     rsp_valid_ff, rsp_valid_in;
   byte_type rsp_char_ff, rsp_char_in;
   logic     rsp_sub_ff, rsp_sub_in;

   logic     out_free;
   logic     s1_move;
   logic     req_take;
   logic     s1_is_cipher;
   byte_type std_char;
   logic     std_alpha;
   sym_type  std_sym;
   sym_type  enc_p, enc_q, dec_q, res_sym;
   sym_type  inner_step;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Standardize the incoming byte and find its rotor positions up front.
   always_comb begin
      std_char = req_char_in;
      if (req_char_in >= CHAR_LC_A && req_char_in <= CHAR_LC_Z) begin
         std_char = req_char_in - CASE_DIFF;
      end
      if (req_char_in == CHAR_SPACE) begin
         std_char = CHAR_HASH;
      end
      std_alpha = (std_char == CHAR_HASH) ||
                  (std_char >= CHAR_UC_A && std_char <= CHAR_UC_Z);
      std_sym   = (std_char == CHAR_HASH) ? '0 : SYM_W'(std_char - UC_BASE);
   end

   assign s1_valid_in = req_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff     <= req_cmd;
         s1_char_ff    <= std_char;
         s1_alpha_ff   <= std_alpha;
         s1_inn_pos_ff <= std_alpha ? INV_INN[std_sym] : '0;
         s1_out_pos_ff <= std_alpha ? INV_OUT[std_sym] : '0;
      end
   end

   // Rotor path.
   always_comb begin
      enc_p   = add_mod(s1_inn_pos_ff, inner_offset_ff);
      enc_q   = add_mod(INV_MID[TAB_OUT[enc_p]], middle_offset_ff);
      dec_q   = INV_OUT[TAB_MID[sub_mod(s1_out_pos_ff, middle_offset_ff)]];
      res_sym = (s1_cmd_ff == CMD_ENCODE) ? TAB_OUT[enc_q]
                                          : TAB_INN[sub_mod(dec_q, inner_offset_ff)];
   end

   assign s1_is_cipher = (s1_cmd_ff == CMD_ENCODE) || (s1_cmd_ff == CMD_DECODE);
   assign inner_step   = add_mod(inner_offset_ff, SYM_W'(1));

   always_comb begin
      inner_offset_in  = inner_offset_ff;
      middle_offset_in = middle_offset_ff;
      if (s1_move) begin
         case (s1_cmd_ff)
            CMD_REWIND: begin
               inner_offset_in  = '0;
               middle_offset_in = '0;
            end
            CMD_ENCODE, CMD_DECODE: begin
               if (s1_alpha_ff) begin
                  inner_offset_in = inner_step;
                  // The middle rotor steps when the inner one wraps home.
                  if (inner_step == '0) begin
                     middle_offset_in = add_mod(middle_offset_ff, SYM_W'(1));
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_offset_ff  <= '0;
         middle_offset_ff <= '0;
      end else begin
         inner_offset_ff  <= inner_offset_in;
         middle_offset_ff <= middle_offset_in;
      end
   end

   // Result register: loaded by cipher commands, held while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_sub_in   = rsp_sub_ff;
      if (s1_move && s1_is_cipher) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = s1_alpha_ff ? sym_to_char(res_sym) : s1_char_ff;
         rsp_sub_in   = s1_alpha_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_sub_ff  <= rsp_sub_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_substituted = rsp_sub_ff;

   // Offsets always stay inside the alphabet.
   offsets_in_range: assert property (@(posedge clock) disable iff (reset)
      inner_offset_ff < SYM_W'(ALPHABET_SIZE) && middle_offset_ff < SYM_W'(ALPHABET_SIZE))
      else $error("rotor offset out of range");

   // A rewind that leaves the input register homes both rotors.
   rewind_homes: assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_cmd_ff == CMD_REWIND |=> inner_offset_ff == '0 && middle_offset_ff == '0)
      else $error("rewind did not home the rotors");

   // An item that leaves the input register with a non-cipher command gives no result.
   result_has_source: assert property (@(posedge clock) disable iff (reset)
      s1_move && !s1_is_cipher && !(rsp_valid_ff && rsp_stall) |=> !rsp_valid_ff)
      else $error("result produced by a command that gives none");

   // A substituted character is always an alphabet symbol.
   sub_in_alphabet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sub_ff |->
         rsp_char_ff == CHAR_HASH || (rsp_char_ff >= CHAR_UC_A && rsp_char_ff <= CHAR_UC_Z))
      else $error("substituted character outside the alphabet");

endmodule
